// File: src/assert_macros.svh
// Assertion macros used by the checker in ppmd_checker.sv.
// Needs a clk and an active-low rst_n in the scope where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/ppmd_pkg.sv
// Types and constants of the PPM frame decoder.
// No dependencies; used by every module of the block.
package ppmd_pkg;

    typedef enum logic
    {
        OP_CAPTURE = 1'b0,
        OP_READ    = 1'b1
    } ppmd_op_t;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMER_TOP          = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_THRESHOLD     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNELS_PER_FRAME = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_WIDTH_US       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_WIDTH_US       = 3'd4;

    localparam logic [15:0] RST_TIMER_TOP          = 16'd40000;
    localparam logic [15:0] RST_SYNC_THRESHOLD     = 16'd8000;
    localparam logic [3:0]  RST_CHANNELS_PER_FRAME = 4'd8;
    localparam logic [14:0] RST_MIN_WIDTH_US       = 15'd900;
    localparam logic [14:0] RST_MAX_WIDTH_US       = 15'd2100;
    localparam logic [15:0] RST_SLOT_WIDTH         = 16'd2400;

    typedef struct packed
    {
        ppmd_op_t    opcode;
        logic [15:0] capture_time;
        logic [2:0]  channel;
    } ppmd_in_t;

    typedef struct packed
    {
        logic [14:0] channel_width_us;
        logic        frame_ready;
    } ppmd_out_t;

    typedef struct packed
    {
        logic [15:0] timer_top;
        logic [15:0] sync_threshold;
        logic [3:0]  channels_per_frame;
        logic [14:0] min_width_us;
        logic [14:0] max_width_us;
    } ppmd_cfg_t;

endpackage

// File: src/ppm_frame_decoder_core.sv
// Top level of the PPM frame decoder: configuration registers, input stage,
// output buffer. Depends on ppmd_pkg and ppmd_decode.
//
// Use:
// - Input channel (in_valid / in_stall / in_word): one word per capture edge
//   (opcode capture, timer value) or per channel read (opcode read, slot).
//   A word is taken at a rising edge with in_valid high and in_stall low.
// - Output channel (out_valid / out_stall / out_word): exactly one word per
//   input word, in order: the clamped width in microseconds on a read (zero
//   on a capture) and the frame-ready flag after that word.
// - Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//   always ready; write only while no word is in flight.
// One word per cycle is sustained with no output stall, set by the single
// input stage feeding a two-entry output buffer. A receiver stall fills the
// spare output entry, then the input stage holds its word and in_stall rises
// until the receiver drains. Reset restores the register defaults, clears the
// slot index, the frame flag and the last capture, and fills every slot with
// 2400 ticks.
module ppm_frame_decoder_core #(
    parameter int SLOT_COUNT = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ppmd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  ppmd_pkg::ppmd_in_t              in_word,
    output logic                            out_valid,
    input  logic                            out_stall,
    output ppmd_pkg::ppmd_out_t             out_word
);
    import ppmd_pkg::*;

    ppmd_cfg_t cfg_reg;

    // input stage
    logic      s1_valid_reg;
    ppmd_in_t  s1_word_reg;
    logic      s1_fire;
    logic      in_take;

    // output buffer: head entry plus one spare entry
    logic      head_valid_reg;
    logic      head_valid_next;
    ppmd_out_t head_word_reg;
    ppmd_out_t head_word_next;
    logic      spare_valid_reg;
    logic      spare_valid_next;
    ppmd_out_t spare_word_reg;
    ppmd_out_t spare_word_next;
    logic      pop;

    ppmd_out_t result;

    assign cfg_ready = 1'b1;

    // hold the register defaults at reset; drop writes to unknown indices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timer_top          <= RST_TIMER_TOP;
            cfg_reg.sync_threshold     <= RST_SYNC_THRESHOLD;
            cfg_reg.channels_per_frame <= RST_CHANNELS_PER_FRAME;
            cfg_reg.min_width_us       <= RST_MIN_WIDTH_US;
            cfg_reg.max_width_us       <= RST_MAX_WIDTH_US;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TIMER_TOP:          cfg_reg.timer_top          <= cfg_data;
                CFG_SYNC_THRESHOLD:     cfg_reg.sync_threshold     <= cfg_data;
                CFG_CHANNELS_PER_FRAME: cfg_reg.channels_per_frame <= cfg_data[3:0];
                CFG_MIN_WIDTH_US:       cfg_reg.min_width_us       <= cfg_data[14:0];
                CFG_MAX_WIDTH_US:       cfg_reg.max_width_us       <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // The input stage advances whenever the spare output entry is free, so
    // in_stall comes straight from registers.
    assign s1_fire  = s1_valid_reg && !spare_valid_reg;
    assign in_stall = s1_valid_reg && spare_valid_reg;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_word_reg <= in_word;
    end

    ppmd_decode #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .fire   (s1_fire),
        .word   (s1_word_reg),
        .result (result)
    );

    assign pop = head_valid_reg && !out_stall;

    // Advance the spare entry into the head on a pop; park a new result in
    // the spare entry when the head is held by a stall.
    always_comb
    begin
        head_valid_next  = head_valid_reg;
        head_word_next   = head_word_reg;
        spare_valid_next = spare_valid_reg;
        spare_word_next  = spare_word_reg;
        if (pop)
        begin
            if (spare_valid_reg)
            begin
                head_word_next   = spare_word_reg;
                spare_valid_next = 1'b0;
            end
            else
            begin
                head_valid_next = s1_fire;
                head_word_next  = result;
            end
        end
        else if (s1_fire)
        begin
            if (head_valid_reg)
            begin
                spare_valid_next = 1'b1;
                spare_word_next  = result;
            end
            else
            begin
                head_valid_next = 1'b1;
                head_word_next  = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg  <= head_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_word_reg  <= head_word_next;
        spare_word_reg <= spare_word_next;
    end

    assign out_valid = head_valid_reg;
    assign out_word  = head_word_reg;

endmodule

// File: src/ppmd_decode.sv
// Decoder state and datapath: interval, slot store, frame flag and clamped read.
// Depends on ppmd_pkg.
module ppmd_decode #(
    parameter int SLOT_COUNT = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ppmd_pkg::ppmd_cfg_t cfg,
    input  logic               fire,
    input  ppmd_pkg::ppmd_in_t  word,
    output ppmd_pkg::ppmd_out_t result
);
    import ppmd_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    logic [15:0]      last_capture_reg;
    logic [CNT_W-1:0] slot_index_reg;
    logic [15:0]      widths_reg [SLOT_COUNT];
    logic             ready_reg;

    logic             is_read;
    logic [15:0]      interval;
    logic             is_sync;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] slot_index_next;
    logic             store;
    logic             ready_next;
    logic [4:0]       chan_ext;
    logic [4:0]       chan_mod;
    logic [IDX_W-1:0] rd_idx;
    logic [14:0]      half_width;
    logic [14:0]      clamped;

    always_comb
    begin
        is_read  = (word.opcode == OP_READ);
        // wrap correction when the timer rolled over since the last edge
        if (word.capture_time < last_capture_reg)
            interval = word.capture_time + cfg.timer_top - last_capture_reg;
        else
            interval = word.capture_time - last_capture_reg;
        is_sync = (interval > cfg.sync_threshold);

        // index may sit one past the last slot: fold it back to slot zero
        if (slot_index_reg == CNT_W'(SLOT_COUNT))
            slot = '0;
        else
            slot = slot_index_reg[IDX_W-1:0];
        slot_index_next = CNT_W'(slot) + CNT_W'(1);
        store           = !is_read && !is_sync;

        priority if (is_read)
            ready_next = 1'b0;
        else if (store && (5'(slot_index_next) >= 5'(cfg.channels_per_frame)))
            ready_next = 1'b1;
        else
            ready_next = ready_reg;

        chan_ext = 5'(word.channel);
        if (chan_ext >= 5'(SLOT_COUNT))
            chan_mod = chan_ext - 5'(SLOT_COUNT);
        else
            chan_mod = chan_ext;
        rd_idx     = chan_mod[IDX_W-1:0];
        half_width = widths_reg[rd_idx][15:1];

        priority if (half_width < cfg.min_width_us)
            clamped = cfg.min_width_us;
        else if (half_width > cfg.max_width_us)
            clamped = cfg.max_width_us;
        else
            clamped = half_width;

        result.channel_width_us = is_read ? clamped : '0;
        result.frame_ready      = ready_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_capture_reg <= '0;
            slot_index_reg   <= '0;
            ready_reg        <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
                widths_reg[i] <= RST_SLOT_WIDTH;
        end
        else if (fire)
        begin
            ready_reg <= ready_next;
            if (!is_read)
            begin
                last_capture_reg <= word.capture_time;
                if (is_sync)
                    slot_index_reg <= '0;
                else
                    slot_index_reg <= slot_index_next;
            end
            if (store)
                widths_reg[slot] <= interval;
        end
    end

endmodule

// File: src/ppmd_checker.sv
// Port-level checks of the PPM frame decoder, bound to its top level.
// Depends on ppmd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ppmd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input ppmd_pkg::ppmd_out_t out_word
);
    import ppmd_pkg::*;

    // a held result keeps its word until taken
    `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "held word moved")

    // the input is only held back while a result waits at the output
    `ASSERT_CLK(a_stall_needs_out, in_stall |-> out_valid, "input stalled with an empty output")

    // with both buffer entries full and the receiver stalled, nothing drains
    `ASSERT_CLK(a_stall_persists, in_stall && out_stall |=> in_stall, "stall released without a drain")

    // reset empties the output at once
    `ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid, "output valid during reset")

endmodule

bind ppm_frame_decoder_core ppmd_checker u_ppmd_checker (.*);
